[design/ksel_pkg.sv]
package ksel_pkg;

  // Field widths fixed by the stream format
  localparam int unsigned VALUE_W = 32;
  localparam int unsigned RANK_W  = 11;

  // Rank register value after reset
  localparam logic [RANK_W-1:0] RANK_RESET = RANK_W'(1);

  // Result status flags, carried on the master-side tuser
  typedef struct packed {
    logic overflow;    // bit 1
    logic rank_error;  // bit 0
  } ksel_flags_t;

endpackage

[design/kth_smallest_select.sv]
// Channel    | Dir | Handshake                   | Word contents
// -----------+-----+-----------------------------+----------------------------------------
// s_axis     | in  | s_axis_tvalid/s_axis_tready | tdata = value, tlast = last of the set
// m_axis     | out | m_axis_tvalid/m_axis_tready | tdata = selected_value,
//            |     |                             | tuser = {overflow, rank_error}
// cfg        | in  | cfg_we_i (single register)  | cfg_wdata_i = rank
//
// Loading: one word per cycle, written into buffer A. After the last word the
// S_START state checks the rank; quickselect then partitions between two ping-pong
// buffers, each pass over the live range followed by S_DECIDE (sorted input is the
// worst case); S_FIN then loads the result register.
// Reset (rst_ni low, async) empties the set and sets rank to 1; no buffer clearing.
// Input stalls during selection and while a result waits behind the previous one.
module kth_smallest_select #(
  parameter int unsigned MAX_VALUES = 1024
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // configuration
  input  logic                          cfg_we_i,
  input  logic [ksel_pkg::RANK_W-1:0]   cfg_wdata_i,   // rank
  // slave side
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  input  logic [ksel_pkg::VALUE_W-1:0]  s_axis_tdata,  // [31:0] value
  input  logic                          s_axis_tlast,
  // master side
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  output logic [ksel_pkg::VALUE_W-1:0]  m_axis_tdata,  // [31:0] selected_value
  output ksel_pkg::ksel_flags_t         m_axis_tuser   // [0] rank_error, [1] overflow
);
  import ksel_pkg::*;

  localparam int unsigned AW = $clog2(MAX_VALUES);
  localparam int unsigned CW = $clog2(MAX_VALUES + 1);
  localparam int unsigned XW = (CW > RANK_W) ? CW : RANK_W;

  localparam logic [CW-1:0] FULL_COUNT = CW'(MAX_VALUES);

  // state codes
  localparam logic [2:0] S_LOAD   = 3'd0;
  localparam logic [2:0] S_START  = 3'd1;
  localparam logic [2:0] S_PASS   = 3'd2;
  localparam logic [2:0] S_DECIDE = 3'd3;
  localparam logic [2:0] S_FIN    = 3'd4;

  logic [2:0]          state_q, state_d;
  logic [RANK_W-1:0]   rank_q, rank_d;
  logic [CW-1:0]       count_q, count_d;
  logic                ovf_q, ovf_d;

  // live range and partition bookkeeping
  logic [AW-1:0]       lo_q, lo_d, hi_q, hi_d;
  logic [AW-1:0]       rd_ptr_q, rd_ptr_d;
  logic [AW-1:0]       wl_q, wl_d, wr_q, wr_d;
  logic [CW-1:0]       lt_q, lt_d, eq_q, eq_d, k_q, k_d;
  logic                src_q, src_d;     // 0: read A / write B, 1: read B / write A
  logic                iss_q, iss_d;
  logic                rv_q, rv_d, rfirst_q, rfirst_d, rlast_q, rlast_d;
  logic [VALUE_W-1:0]  piv_q, piv_d;

  // result register
  logic                m_valid_q, m_valid_d;
  logic [VALUE_W-1:0]  m_data_q, m_data_d;
  ksel_flags_t         m_flags_q, m_flags_d;
  logic [VALUE_W-1:0]  res_val_q, res_val_d;
  logic                res_err_q, res_err_d;

  // ping-pong buffers
  logic [VALUE_W-1:0]  mem_a [MAX_VALUES];
  logic [VALUE_W-1:0]  mem_b [MAX_VALUES];
  logic [VALUE_W-1:0]  rd_a_q, rd_b_q;
  logic                we_a, we_b;
  logic [AW-1:0]       wa_a, wa_b;
  logic [VALUE_W-1:0]  wd_a, wd_b;

  // scratch
  logic [VALUE_W-1:0]  rdata, pivot;
  logic [AW-1:0]       wa_pass, new_lo, new_hi;
  logic                we_pass;
  logic [CW-1:0]       le_cnt;
  logic                in_acc, full;

  assign s_axis_tready = (state_q == S_LOAD);
  assign in_acc        = s_axis_tvalid && s_axis_tready;
  assign full          = (count_q == FULL_COUNT);
  assign rdata         = src_q ? rd_b_q : rd_a_q;
  assign pivot         = rfirst_q ? rdata : piv_q;
  assign le_cnt        = lt_q + eq_q;

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_data_q;
  assign m_axis_tuser  = m_flags_q;

  // next-state logic
  always_comb begin
    state_d   = state_q;
    rank_d    = cfg_we_i ? cfg_wdata_i : rank_q;
    count_d   = count_q;
    ovf_d     = ovf_q;
    lo_d      = lo_q;
    hi_d      = hi_q;
    rd_ptr_d  = rd_ptr_q;
    wl_d      = wl_q;
    wr_d      = wr_q;
    lt_d      = lt_q;
    eq_d      = eq_q;
    k_d       = k_q;
    src_d     = src_q;
    iss_d     = iss_q;
    rv_d      = 1'b0;
    rfirst_d  = 1'b0;
    rlast_d   = 1'b0;
    piv_d     = piv_q;
    res_val_d = res_val_q;
    res_err_d = res_err_q;
    m_valid_d = m_valid_q && !m_axis_tready;
    m_data_d  = m_data_q;
    m_flags_d = m_flags_q;
    we_a      = 1'b0;
    wa_a      = count_q[AW-1:0];
    wd_a      = s_axis_tdata;
    we_b      = 1'b0;
    wa_b      = '0;
    wd_b      = rdata;
    we_pass   = 1'b0;
    wa_pass   = wl_q;
    new_lo    = lo_q;
    new_hi    = hi_q;

    unique case (state_q)
      S_LOAD: begin
        if (in_acc) begin
          if (!full) begin
            we_a    = 1'b1;
            count_d = count_q + CW'(1);
          end else begin
            ovf_d = 1'b1;
          end
          if (s_axis_tlast) begin
            state_d = S_START;
          end
        end
      end

      S_START: begin
        if ((rank_q == '0) || (XW'(rank_q) > XW'(count_q))) begin
          res_val_d = '0;
          res_err_d = 1'b1;
          state_d   = S_FIN;
        end else begin
          res_err_d = 1'b0;
          k_d       = CW'(rank_q);
          new_lo    = '0;
          new_hi    = AW'(count_q - CW'(1));
          lo_d      = new_lo;
          hi_d      = new_hi;
          rd_ptr_d  = new_lo;
          wl_d      = new_lo;
          wr_d      = new_hi;
          lt_d      = '0;
          eq_d      = '0;
          src_d     = 1'b0;
          iss_d     = 1'b1;
          state_d   = S_PASS;
        end
      end

      S_PASS: begin
        // read side: stream the range lo..hi
        if (iss_q) begin
          rd_ptr_d = rd_ptr_q + AW'(1);
          rv_d     = 1'b1;
          rfirst_d = (rd_ptr_q == lo_q);
          rlast_d  = (rd_ptr_q == hi_q);
          if (rd_ptr_q == hi_q) begin
            iss_d = 1'b0;
          end
        end
        // partition side: smaller from the left, larger from the right
        if (rv_q) begin
          piv_d = pivot;
          if ($signed(rdata) < $signed(pivot)) begin
            we_pass = 1'b1;
            wa_pass = wl_q;
            wl_d    = wl_q + AW'(1);
            lt_d    = lt_q + CW'(1);
          end else if ($signed(rdata) > $signed(pivot)) begin
            we_pass = 1'b1;
            wa_pass = wr_q;
            wr_d    = wr_q - AW'(1);
          end else begin
            eq_d = eq_q + CW'(1);
          end
          if (rlast_q) begin
            state_d = S_DECIDE;
          end
        end
        we_a = we_pass && src_q;
        wa_a = wa_pass;
        wd_a = rdata;
        we_b = we_pass && !src_q;
        wa_b = wa_pass;
      end

      S_DECIDE: begin
        if ((k_q > lt_q) && (k_q <= le_cnt)) begin
          res_val_d = piv_q;
          state_d   = S_FIN;
        end else begin
          if (k_q <= lt_q) begin
            new_lo = lo_q;
            new_hi = lo_q + lt_q[AW-1:0] - AW'(1);
          end else begin
            new_lo = wr_q + AW'(1);
            new_hi = hi_q;
            k_d    = k_q - le_cnt;
          end
          lo_d     = new_lo;
          hi_d     = new_hi;
          rd_ptr_d = new_lo;
          wl_d     = new_lo;
          wr_d     = new_hi;
          lt_d     = '0;
          eq_d     = '0;
          src_d    = !src_q;
          iss_d    = 1'b1;
          state_d  = S_PASS;
        end
      end

      S_FIN: begin
        if (!m_valid_q || m_axis_tready) begin
          m_valid_d            = 1'b1;
          m_data_d             = res_val_q;
          m_flags_d.rank_error = res_err_q;
          m_flags_d.overflow   = ovf_q;
          count_d              = '0;
          ovf_d                = 1'b0;
          state_d              = S_LOAD;
        end
      end

      default: begin
        state_d = S_LOAD;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_LOAD;
      rank_q    <= RANK_RESET;
      count_q   <= '0;
      ovf_q     <= 1'b0;
      iss_q     <= 1'b0;
      rv_q      <= 1'b0;
      rfirst_q  <= 1'b0;
      rlast_q   <= 1'b0;
      m_valid_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      rank_q    <= rank_d;
      count_q   <= count_d;
      ovf_q     <= ovf_d;
      iss_q     <= iss_d;
      rv_q      <= rv_d;
      rfirst_q  <= rfirst_d;
      rlast_q   <= rlast_d;
      m_valid_q <= m_valid_d;
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    lo_q      <= lo_d;
    hi_q      <= hi_d;
    rd_ptr_q  <= rd_ptr_d;
    wl_q      <= wl_d;
    wr_q      <= wr_d;
    lt_q      <= lt_d;
    eq_q      <= eq_d;
    k_q       <= k_d;
    src_q     <= src_d;
    piv_q     <= piv_d;
    res_val_q <= res_val_d;
    res_err_q <= res_err_d;
    m_data_q  <= m_data_d;
    m_flags_q <= m_flags_d;
  end

  // buffer A: one write, one registered read
  always_ff @(posedge clk_i) begin
    if (we_a) begin
      mem_a[wa_a] <= wd_a;
    end
    rd_a_q <= mem_a[rd_ptr_q];
  end

  // buffer B: one write, one registered read
  always_ff @(posedge clk_i) begin
    if (we_b) begin
      mem_b[wa_b] <= wd_b;
    end
    rd_b_q <= mem_b[rd_ptr_q];
  end

  // a rank error always comes with a zero value
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser.rank_error |-> m_axis_tdata == '0)
    else $error("rank error with nonzero value");

  // the fill count never passes the buffer depth
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= FULL_COUNT)
    else $error("element count beyond depth");

  // partition counts stay within the live range
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_PASS) |-> (XW'(le_cnt) <= XW'(hi_q - lo_q) + XW'(1)))
    else $error("partition counts exceed range");

  // the wanted rank stays inside the live range
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_PASS) |-> (k_q != '0) && (XW'(k_q) <= XW'(hi_q - lo_q) + XW'(1)))
    else $error("rank outside live range");

  // the read pointer stays in range while issuing
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_PASS) && iss_q |-> (rd_ptr_q >= lo_q) && (rd_ptr_q <= hi_q))
    else $error("read pointer outside range");

endmodule

[dv/tb.sv]
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import ksel_pkg::*;

  localparam int unsigned MAX_VALUES = 1024;

  // expected result of one set
  typedef struct packed {
    logic [VALUE_W-1:0] sel;
    ksel_flags_t        flags;
  } pick_t;

  logic                clk_i;
  logic                rst_ni;
  logic                cfg_we_i;
  logic [RANK_W-1:0]   cfg_wdata_i;   // rank
  logic                s_axis_tvalid;
  logic                s_axis_tready;
  logic [VALUE_W-1:0]  s_axis_tdata;  // [31:0] value
  logic                s_axis_tlast;
  logic                m_axis_tvalid;
  logic                m_axis_tready;
  logic [VALUE_W-1:0]  m_axis_tdata;  // [31:0] selected_value
  ksel_flags_t         m_axis_tuser;  // [0] rank_error, [1] overflow

  // shadow state of the selector
  logic signed [VALUE_W-1:0] load_set[$];
  logic                      drop_seen = 1'b0;
  logic [RANK_W-1:0]         rank_reg = RANK_RESET;
  pick_t                     pick_q[$];

  int err_cnt   = 0;
  int res_cnt   = 0;
  int snk_hold  = 0;
  bit src_idle_en = 1'b1;
  bit snk_idle_en = 1'b1;

  kth_smallest_select #(
    .MAX_VALUES(MAX_VALUES)
  ) u_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tlast (s_axis_tlast),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser)
  );

  // 12 ns clock
  initial begin
    clk_i = 1'b0;
    forever #6ns clk_i = ~clk_i;
  end

  // run limit
  initial begin
    #36ms;
    $display("CHECKS FAILED");
    $finish;
  end

  // k-th smallest of a set, k counted from 1, signed order
  function automatic logic [VALUE_W-1:0] pick_kth(input logic signed [VALUE_W-1:0] vals[$],
                                                  input int unsigned k);
    logic signed [VALUE_W-1:0] srt[$];
    logic signed [VALUE_W-1:0] key;
    int j;
    srt = vals;
    for (int i = 1; i < srt.size(); i++) begin
      key = srt[i];
      j = i - 1;
      while (j >= 0 && srt[j] > key) begin
        srt[j+1] = srt[j];
        j--;
      end
      srt[j+1] = key;
    end
    return srt[k-1];
  endfunction

  task automatic report(input string msg);
    err_cnt++;
    if (err_cnt <= 10) $display("%s", msg);
  endtask

  // track config, load words, and check results, all on pre-edge values
  always @(posedge clk_i) begin
    pick_t want;
    pick_t got;
    if (rst_ni) begin
      if (m_axis_tvalid && m_axis_tready) begin
        got.sel   = m_axis_tdata;
        got.flags = m_axis_tuser;
        res_cnt++;
        if (pick_q.size() == 0) begin
          report($sformatf("unexpected result: value %h err %b ovf %b",
                           got.sel, got.flags.rank_error, got.flags.overflow));
        end else begin
          want = pick_q.pop_front();
          if (got.sel !== want.sel || got.flags.rank_error !== want.flags.rank_error ||
              got.flags.overflow !== want.flags.overflow) begin
            report($sformatf("result %0d: exp value %h err %b ovf %b, got value %h err %b ovf %b",
                             res_cnt, want.sel, want.flags.rank_error, want.flags.overflow,
                             got.sel, got.flags.rank_error, got.flags.overflow));
          end
        end
      end
      if (cfg_we_i) rank_reg = cfg_wdata_i;
      if (s_axis_tvalid && s_axis_tready) begin
        if (load_set.size() < MAX_VALUES) load_set.push_back(s_axis_tdata);
        else drop_seen = 1'b1;
        if (s_axis_tlast) begin
          want.flags.overflow = drop_seen;
          if (rank_reg == 0 || rank_reg > load_set.size()) begin
            want.sel              = '0;
            want.flags.rank_error = 1'b1;
          end else begin
            want.sel              = pick_kth(load_set, rank_reg);
            want.flags.rank_error = 1'b0;
          end
          pick_q.push_back(want);
          load_set.delete();
          drop_seen = 1'b0;
        end
      end
    end
  end

  // result side: random stalls, plus a long hold when a test asks for one
  initial begin
    int stall_left;
    stall_left = 0;
    m_axis_tready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (snk_hold != 0) begin
        m_axis_tready <= 1'b0;
        snk_hold--;
      end else if (stall_left != 0) begin
        m_axis_tready <= 1'b0;
        stall_left--;
      end else if (snk_idle_en && $urandom_range(0, 3) == 0) begin
        m_axis_tready <= 1'b0;
        stall_left = $urandom_range(0, 4);
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  // offer one word, with an occasional gap first, and wait for it to be taken
  task automatic send_word(input logic [VALUE_W-1:0] v, input logic lst);
    if (src_idle_en && $urandom_range(0, 3) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= v;
    s_axis_tlast  <= lst;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
  endtask

  task automatic send_set(input logic [VALUE_W-1:0] vals[$]);
    foreach (vals[i]) send_word(vals[i], i == vals.size() - 1);
  endtask

  // drop valid and wait until every expected result is back
  task automatic wait_quiet();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (pick_q.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  // rank write, only with the block idle
  task automatic write_rank(input logic [RANK_W-1:0] r);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= r;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    @(posedge clk_i);
  endtask

  function automatic logic [VALUE_W-1:0] rand_value();
    case ($urandom_range(0, 5))
      0, 1, 2: return $urandom;
      3:       return VALUE_W'($signed($urandom_range(0, 16)) - 8);
      4: begin
        case ($urandom_range(0, 3))
          0:       return 32'h7FFF_FFFF;
          1:       return 32'h8000_0000;
          2:       return 32'h0000_0000;
          default: return 32'hFFFF_FFFF;
        endcase
      end
      default: return VALUE_W'($urandom_range(0, 3));
    endcase
  endfunction

  // reset rank of 1, then extremes of the value range
  task automatic test_directed_ranks();
    send_set('{32'd5});
    send_set('{32'h0, 32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF, 32'h1});
    wait_quiet();
    write_rank(11'd5);
    send_set('{32'h0, 32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF, 32'h1});
    wait_quiet();
  endtask

  // rank zero, all-ones rank, rank one past the count, duplicates
  task automatic test_rank_errors();
    write_rank(11'd0);
    send_set('{32'd3, 32'd1});
    wait_quiet();
    write_rank(11'h7FF);
    send_set('{32'hFFFF_FFFF});
    wait_quiet();
    write_rank(11'd3);
    send_set('{32'd9, -32'sd9, 32'd9});
    wait_quiet();
    write_rank(11'd4);
    send_set('{32'd9, -32'sd9, 32'd9});
    wait_quiet();
  endtask

  // sorted, reverse sorted and all-equal sets
  task automatic test_ordered_sets();
    write_rank(11'd4);
    send_set('{-32'sd3, -32'sd2, -32'sd1, 32'd0, 32'd1, 32'd2});
    send_set('{32'd60, 32'd50, 32'd40, 32'd30, 32'd20, 32'd10});
    send_set('{32'hDEAD_BEEF, 32'hDEAD_BEEF, 32'hDEAD_BEEF, 32'hDEAD_BEEF});
    wait_quiet();
  endtask

  // receiver holds off while sets keep coming, so the input stalls
  task automatic test_backpressure();
    write_rank(11'd2);
    snk_hold = 400;
    for (int s = 0; s < 4; s++) begin
      for (int i = 0; i < 5; i++) send_word(rand_value(), i == 4);
    end
    wait_quiet();
  endtask

  // a set that fills the store and then spills over
  task automatic test_full_store();
    write_rank(11'd1024);
    // dropped words are larger than any stored one, last one among them
    for (int i = 0; i < MAX_VALUES; i++) send_word($urandom_range(0, 32'h3FFF_FFFF), 1'b0);
    send_word(32'h7FFF_FFFF, 1'b0);
    send_word(32'h7FFF_FFFE, 1'b1);
    wait_quiet();
  endtask

  // random sets in phases, each with its own rank
  task automatic test_random_sets();
    int sent;
    int size;
    logic [RANK_W-1:0] r;
    for (int ph = 0; ph < 8; ph++) begin
      wait_quiet();
      case ($urandom_range(0, 9))
        0, 1, 2, 3: r = RANK_W'($urandom_range(1, 6));
        4, 5, 6:    r = RANK_W'($urandom_range(1, 40));
        7:          r = '0;
        8:          r = RANK_W'($urandom_range(1024, 2047));
        default:    r = RANK_W'($urandom_range(1, 1024));
      endcase
      write_rank(r);
      // no idling in the last two phases
      src_idle_en = (ph < 6) && ($urandom_range(0, 3) != 0);
      snk_idle_en = (ph < 6) && ($urandom_range(0, 3) != 0);
      sent = 0;
      while (sent < 64) begin
        size = ($urandom_range(0, 7) == 0) ? $urandom_range(13, 40) : $urandom_range(1, 12);
        for (int i = 0; i < size; i++) send_word(rand_value(), i == size - 1);
        sent += size;
      end
    end
  endtask

  initial begin
    rst_ni        <= 1'b0;
    cfg_we_i      <= 1'b0;
    cfg_wdata_i   <= '0;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata  <= '0;
    s_axis_tlast  <= 1'b0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_directed_ranks();
    test_rank_errors();
    test_ordered_sets();
    test_backpressure();
    test_full_store();
    test_random_sets();

    wait_quiet();
    repeat (20) @(posedge clk_i);
    err_cnt += pick_q.size();
    if (err_cnt == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

[sim.f]
design/ksel_pkg.sv
design/kth_smallest_select.sv
dv/tb.sv
